FILE: hw/rtl/srtfi_pkg.sv
// ----------------------------------------------------------------------------
// S-record to flash image: shared package
// Types, character codes and register indexes used by the parser blocks.
// ----------------------------------------------------------------------------
package srtfi_pkg;

  // Character codes of the record text.
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_TWO  = 8'h32;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_EIGHT = 8'h38;

  // Value that a non-hex character decodes to.
  localparam logic [7:0] BAD_NIBBLE = 8'hFF;
  // Data byte shown on an end word.
  localparam logic [7:0] END_FILL = 8'hFF;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PACK_LENGTH  = 8'd1;
  localparam logic [16:0] PACK_RESET = 17'd512;

  // Result kinds.
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [3:0] {
    PH_WAIT_LF  = 4'd0,
    PH_AT_LINE  = 4'd1,
    PH_S_LINE   = 4'd2,
    PH_S_MID    = 4'd3,
    PH_LEN      = 4'd4,
    PH_ADDR     = 4'd5,
    PH_DATA_HI  = 4'd6,
    PH_DATA_LO  = 4'd7,
    PH_ENDED    = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_DONE = 2'd2
  } back_state_e;

  // One word passed from the parser to the output side.
  typedef struct packed {
    logic        kind;
    logic [31:0] offset;
    logic [7:0]  data;
    logic        err;
  } item_t;

  // Decode one ASCII hex digit; anything else gives BAD_NIBBLE.
  function automatic logic [7:0] hex_val(input logic [7:0] c);
    logic [7:0] r;
    r = BAD_NIBBLE;
    if (c >= 8'h30 && c <= 8'h39) r = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) r = c - 8'h37;
    else if (c >= 8'h61 && c <= 8'h66) r = c - 8'h57;
    return r;
  endfunction

endpackage

FILE: hw/rtl/srtfi_front.sv
// ----------------------------------------------------------------------------
// S-record to flash image: parser front end
// Walks the text one character per cycle while fire_i is high and emits data and end words.
// ----------------------------------------------------------------------------
module srtfi_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [7:0]           char_i,
  input  logic [31:0]          base_address_i,
  output logic                 push_o,
  output srtfi_pkg::item_t     item_o
);

  srtfi_pkg::phase_e phase_q, phase_d;
  logic        s3_q, s3_d;
  logic [3:0]  nib_q, nib_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  rem_q, rem_d;
  logic [31:0] addr_q, addr_d;
  logic [31:0] lbase_q, lbase_d;
  logic        hdr_q, hdr_d;
  logic        blat_q, blat_d;
  logic [7:0]  byte_q, byte_d;
  logic [31:0] last_q, last_d;
  logic        err_q, err_d;

  logic [7:0]  v;
  logic        is_lf;
  logic [31:0] addr_shift;
  logic        addr_done;
  logic [7:0]  overhead;
  logic [7:0]  bytes_left;
  logic [7:0]  byte_new;
  logic [7:0]  rem_dec;
  logic [31:0] offset;
  logic        in_record;

  // Shared decode of the current character.
  assign v          = srtfi_pkg::hex_val(char_i);
  assign is_lf      = (char_i == srtfi_pkg::CH_LF);
  assign addr_shift = {addr_q[27:0], 4'b0000} | {24'd0, v};
  assign addr_done  = (nib_q + 4'd1) >= (s3_q ? 4'd8 : 4'd6);
  assign overhead   = s3_q ? 8'd5 : 8'd4;
  assign bytes_left = (len_q >= overhead) ? (len_q - overhead) : 8'd0;
  assign byte_new   = {byte_q[3:0], 4'b0000} | v;
  assign rem_dec    = rem_q - 8'd1;
  assign offset     = addr_q - (hdr_q ? lbase_q : base_address_i);
  assign in_record  = (phase_q == srtfi_pkg::PH_LEN) || (phase_q == srtfi_pkg::PH_ADDR) ||
                      (phase_q == srtfi_pkg::PH_DATA_HI) || (phase_q == srtfi_pkg::PH_DATA_LO);

  // Next parse phase.
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      srtfi_pkg::PH_WAIT_LF, srtfi_pkg::PH_S_MID, srtfi_pkg::PH_AT_LINE: begin
        if (is_lf) phase_d = srtfi_pkg::PH_AT_LINE;
        else if (char_i == srtfi_pkg::CH_S)
          phase_d = (phase_q == srtfi_pkg::PH_AT_LINE) ? srtfi_pkg::PH_S_LINE
                                                      : srtfi_pkg::PH_S_MID;
        else phase_d = srtfi_pkg::PH_WAIT_LF;
      end
      srtfi_pkg::PH_S_LINE: begin
        if (char_i == srtfi_pkg::CH_ZERO) phase_d = srtfi_pkg::PH_WAIT_LF;
        else if (char_i == srtfi_pkg::CH_TWO || char_i == srtfi_pkg::CH_THREE)
          phase_d = srtfi_pkg::PH_LEN;
        else if (char_i == srtfi_pkg::CH_SEVEN || char_i == srtfi_pkg::CH_EIGHT)
          phase_d = srtfi_pkg::PH_ENDED;
        else if (is_lf) phase_d = srtfi_pkg::PH_AT_LINE;
        else if (char_i == srtfi_pkg::CH_S) phase_d = srtfi_pkg::PH_S_MID;
        else phase_d = srtfi_pkg::PH_WAIT_LF;
      end
      srtfi_pkg::PH_LEN: begin
        if (is_lf) phase_d = srtfi_pkg::PH_AT_LINE;
        else if (nib_q != 4'd0) phase_d = srtfi_pkg::PH_ADDR;
      end
      srtfi_pkg::PH_ADDR: begin
        if (is_lf) phase_d = srtfi_pkg::PH_AT_LINE;
        else if (addr_done)
          phase_d = (bytes_left == 8'd0) ? srtfi_pkg::PH_WAIT_LF : srtfi_pkg::PH_DATA_HI;
      end
      srtfi_pkg::PH_DATA_HI: begin
        if (is_lf) phase_d = srtfi_pkg::PH_AT_LINE;
        else phase_d = srtfi_pkg::PH_DATA_LO;
      end
      srtfi_pkg::PH_DATA_LO: begin
        if (is_lf) phase_d = srtfi_pkg::PH_AT_LINE;
        else phase_d = (rem_dec == 8'd0) ? srtfi_pkg::PH_WAIT_LF : srtfi_pkg::PH_DATA_HI;
      end
      srtfi_pkg::PH_ENDED: phase_d = srtfi_pkg::PH_ENDED;
      default: phase_d = srtfi_pkg::PH_WAIT_LF;
    endcase
  end

  // Datapath updates and emitted words.
  always_comb begin
    s3_d    = s3_q;
    nib_d   = nib_q;
    len_d   = len_q;
    rem_d   = rem_q;
    addr_d  = addr_q;
    lbase_d = lbase_q;
    hdr_d   = hdr_q;
    blat_d  = blat_q;
    byte_d  = byte_q;
    last_d  = last_q;
    err_d   = err_q;
    push_o  = 1'b0;
    item_o  = '{kind: srtfi_pkg::KIND_DATA, offset: offset, data: byte_new, err: err_q};
    case (phase_q)
      srtfi_pkg::PH_S_MID: begin
        if (char_i == srtfi_pkg::CH_ZERO) hdr_d = 1'b1;
      end
      srtfi_pkg::PH_S_LINE: begin
        if (char_i == srtfi_pkg::CH_ZERO) begin
          hdr_d = 1'b1;
        end else if (char_i == srtfi_pkg::CH_TWO || char_i == srtfi_pkg::CH_THREE) begin
          s3_d   = (char_i == srtfi_pkg::CH_THREE);
          nib_d  = 4'd0;
          len_d  = 8'd0;
          addr_d = 32'd0;
          err_d  = 1'b0;
        end else if (char_i == srtfi_pkg::CH_SEVEN || char_i == srtfi_pkg::CH_EIGHT) begin
          push_o = 1'b1;
          item_o = '{kind: srtfi_pkg::KIND_END, offset: last_q,
                     data: srtfi_pkg::END_FILL, err: err_q};
          err_d  = 1'b0;
        end
      end
      default: ;
    endcase
    if (in_record && !is_lf) begin
      if (v == srtfi_pkg::BAD_NIBBLE) err_d = 1'b1;
      case (phase_q)
        srtfi_pkg::PH_LEN: begin
          len_d = {len_q[3:0], 4'b0000} | v;
          nib_d = (nib_q != 4'd0) ? 4'd0 : 4'd1;
        end
        srtfi_pkg::PH_ADDR: begin
          addr_d = addr_shift;
          nib_d  = nib_q + 4'd1;
          if (addr_done) begin
            nib_d = 4'd0;
            if (hdr_q && !blat_q) begin
              lbase_d = addr_shift;
              blat_d  = 1'b1;
            end
            rem_d = bytes_left;
          end
        end
        srtfi_pkg::PH_DATA_HI: byte_d = byte_new;
        srtfi_pkg::PH_DATA_LO: begin
          // A bad low digit is reported on the word it completes.
          item_o.err = err_q | (v == srtfi_pkg::BAD_NIBBLE);
          byte_d = byte_new;
          push_o = 1'b1;
          err_d  = 1'b0;
          last_d = offset;
          addr_d = addr_q + 32'd1;
          rem_d  = rem_dec;
        end
        default: ;
      endcase
    end
    push_o = push_o & fire_i;
  end

  // Control state is reset; the accumulators are cleared too as the parse depends on them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= srtfi_pkg::PH_WAIT_LF;
      s3_q    <= 1'b0;
      nib_q   <= 4'd0;
      len_q   <= 8'd0;
      rem_q   <= 8'd0;
      addr_q  <= 32'd0;
      lbase_q <= 32'd0;
      hdr_q   <= 1'b0;
      blat_q  <= 1'b0;
      byte_q  <= 8'd0;
      last_q  <= 32'd0;
      err_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      s3_q    <= s3_d;
      nib_q   <= nib_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      addr_q  <= addr_d;
      lbase_q <= lbase_d;
      hdr_q   <= hdr_d;
      blat_q  <= blat_d;
      byte_q  <= byte_d;
      last_q  <= last_d;
      err_q   <= err_d;
    end
  end

endmodule

FILE: hw/rtl/srtfi_queue.sv
// ----------------------------------------------------------------------------
// S-record to flash image: word queue
// Two-entry queue between the parser and the output side.
// ----------------------------------------------------------------------------
module srtfi_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  srtfi_pkg::item_t wdata_i,
  input  logic             rd_i,
  output srtfi_pkg::item_t rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  srtfi_pkg::item_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rptr_q];

  // Storage is written without reset.
  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wptr_q] <= wdata_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr_i) wptr_q <= ~wptr_q;
      if (rd_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, wr_i} - {1'b0, rd_i};
    end
  end

endmodule

FILE: hw/rtl/srtfi_back.sv
// ----------------------------------------------------------------------------
// S-record to flash image: output back end
// Holds the output word and rounds the final length with a serial remainder.
// ----------------------------------------------------------------------------
module srtfi_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [16:0]      pack_length_i,
  input  logic             q_empty_i,
  input  srtfi_pkg::item_t q_item_i,
  output logic             q_rd_o,
  input  logic             pop_i,
  output logic             out_valid_o,
  output srtfi_pkg::item_t out_item_o,
  output logic [31:0]      out_padded_o
);

  srtfi_pkg::back_state_e state_q, state_d;
  logic [4:0]  cnt_q;
  logic [31:0] val_q;
  logic [31:0] shf_q;
  logic [16:0] rem_q;
  logic        err_q;
  logic        ov_q;
  srtfi_pkg::item_t oitem_q;
  logic [31:0] opad_q;

  logic        pop_fire;
  logic        slot_free;
  logic        load_data;
  logic        load_end;
  logic [17:0] trial;
  logic [16:0] rem_next;
  logic [31:0] padded;

  assign pop_fire  = pop_i & ov_q;
  assign slot_free = ~ov_q | pop_fire;

  // One restoring remainder step per cycle.
  assign trial    = {rem_q, shf_q[31]};
  assign rem_next = (trial >= {1'b0, pack_length_i}) ? 17'(trial - {1'b0, pack_length_i})
                                                     : trial[16:0];
  assign padded   = (pack_length_i == 17'd0 || rem_q == 17'd0) ? val_q
                  : val_q + ({15'd0, pack_length_i} - {15'd0, rem_q});

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      srtfi_pkg::BK_IDLE:
        if (!q_empty_i && slot_free && q_item_i.kind == srtfi_pkg::KIND_END)
          state_d = srtfi_pkg::BK_DIV;
      srtfi_pkg::BK_DIV:  if (cnt_q == 5'd31) state_d = srtfi_pkg::BK_DONE;
      srtfi_pkg::BK_DONE: if (slot_free) state_d = srtfi_pkg::BK_IDLE;
      default: state_d = srtfi_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    q_rd_o    = 1'b0;
    load_data = 1'b0;
    load_end  = 1'b0;
    case (state_q)
      srtfi_pkg::BK_IDLE: begin
        q_rd_o    = ~q_empty_i & slot_free;
        load_data = q_rd_o & (q_item_i.kind == srtfi_pkg::KIND_DATA);
      end
      srtfi_pkg::BK_DONE: load_end = slot_free;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srtfi_pkg::BK_IDLE;
      cnt_q   <= 5'd0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == srtfi_pkg::BK_DIV) cnt_q <= cnt_q + 5'd1;
      else cnt_q <= 5'd0;
      if (load_data || load_end) ov_q <= 1'b1;
      else if (pop_fire) ov_q <= 1'b0;
    end
  end

  // Divider and output word registers.
  always_ff @(posedge clk_i) begin
    if (state_q == srtfi_pkg::BK_IDLE && q_rd_o) begin
      val_q <= q_item_i.offset;
      shf_q <= q_item_i.offset;
      rem_q <= 17'd0;
      err_q <= q_item_i.err;
    end else if (state_q == srtfi_pkg::BK_DIV) begin
      shf_q <= {shf_q[30:0], 1'b0};
      rem_q <= rem_next;
    end
    if (load_data) begin
      oitem_q <= q_item_i;
      opad_q  <= 32'd0;
    end else if (load_end) begin
      oitem_q <= '{kind: srtfi_pkg::KIND_END, offset: val_q,
                   data: srtfi_pkg::END_FILL, err: err_q};
      opad_q  <= padded;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_item_o   = oitem_q;
  assign out_padded_o = opad_q;

endmodule

FILE: hw/rtl/srec_to_flash_image_top.sv
// ----------------------------------------------------------------------------
// S-record to flash image: top level
// Parses S2/S3 record text into offset-tagged data bytes and a final length.
// ----------------------------------------------------------------------------
// The block takes one character of S-record text per cycle while full is
// low. A parser front end decodes records and hands each data byte, and
// the single end word, to a two-entry queue; full rises when that queue
// holds two words. A data word is written into the queue and then moves
// into the output register once that register is free. The end word first
// passes through the bit-serial remainder unit that rounds the last offset
// up to a multiple of pack_length, one quotient bit per cycle. After an end
// record all further text is swallowed until reset.
module srec_to_flash_image_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_in_i,
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [31:0] byte_offset_o,
  output logic [7:0]  data_byte_o,
  output logic [31:0] padded_length_o,
  output logic        hex_error_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [srtfi_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] base_q;
  logic [16:0] pack_q;
  logic        fire;
  logic        f_push;
  srtfi_pkg::item_t f_item;
  logic        q_rd, q_full, q_empty;
  srtfi_pkg::item_t q_item;
  logic        ov;
  srtfi_pkg::item_t o_item;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 32'd0;
      pack_q <= srtfi_pkg::PACK_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == srtfi_pkg::REG_BASE_ADDRESS) base_q <= cfg_data_i;
      else if (cfg_index_i == srtfi_pkg::REG_PACK_LENGTH) pack_q <= cfg_data_i[16:0];
    end
  end

  assign full = q_full;
  assign fire = push & ~q_full;

  srtfi_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .char_i         (char_in_i),
    .base_address_i (base_q),
    .push_o         (f_push),
    .item_o         (f_item)
  );

  srtfi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (f_push),
    .wdata_i (f_item),
    .rd_i    (q_rd),
    .rdata_o (q_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  srtfi_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pack_length_i (pack_q),
    .q_empty_i     (q_empty),
    .q_item_i      (q_item),
    .q_rd_o        (q_rd),
    .pop_i         (pop),
    .out_valid_o   (ov),
    .out_item_o    (o_item),
    .out_padded_o  (padded_length_o)
  );

  assign empty         = ~ov;
  assign kind_o        = o_item.kind;
  assign byte_offset_o = o_item.offset;
  assign data_byte_o   = o_item.data;
  assign hex_error_o   = o_item.err;

endmodule

FILE: hw/rtl/srtfi_checker.sv
// ----------------------------------------------------------------------------
// S-record to flash image: port checker
// Watches the top-level ports for output word rules.
// ----------------------------------------------------------------------------
module srtfi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic        kind_o,
  input logic [31:0] byte_offset_o,
  input logic [7:0]  data_byte_o,
  input logic [31:0] padded_length_o
);

  // A waiting word holds until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(byte_offset_o) && $stable(kind_o)))
    else $error("output word changed while waiting");

  // Nothing follows the end word.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && kind_o) |=> empty)
    else $error("word after end word");

  // Data words carry no length.
  a_dlen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !kind_o) |-> (padded_length_o == 32'd0))
    else $error("data word with length");

  // End words carry the fill byte.
  a_efill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o) |-> (data_byte_o == srtfi_pkg::END_FILL))
    else $error("end word without fill byte");

endmodule

bind srec_to_flash_image_top srtfi_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .empty           (empty),
  .pop             (pop),
  .kind_o          (kind_o),
  .byte_offset_o   (byte_offset_o),
  .data_byte_o     (data_byte_o),
  .padded_length_o (padded_length_o)
);
